/* sv/rcb_pkg.sv */
// Shared types and codes of the RGBA color blend unit.
package rcb_pkg;

  localparam int unsigned FACTOR_W = 4;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned STAGES     = 4;

  typedef enum logic [FACTOR_W-1:0] {
    FACT_ZERO          = 4'd0,
    FACT_ONE           = 4'd1,
    FACT_SRC_COL       = 4'd2,
    FACT_SRC_ALPHA     = 4'd3,
    FACT_DST_COL       = 4'd4,
    FACT_DST_ALPHA     = 4'd5,
    FACT_INV_SRC_COL   = 4'd6,
    FACT_INV_SRC_ALPHA = 4'd7,
    FACT_INV_DST_COL   = 4'd8,
    FACT_INV_DST_ALPHA = 4'd9
  } factor_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_REV_SUB = 3'd2,
    OP_MIN     = 3'd3,
    OP_MAX     = 3'd4
  } blend_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RGB_SRC_FACTOR   = 3'd0,
    REG_RGB_DST_FACTOR   = 3'd1,
    REG_ALPHA_SRC_FACTOR = 3'd2,
    REG_ALPHA_DST_FACTOR = 3'd3,
    REG_RGB_BLEND_OP     = 3'd4,
    REG_ALPHA_BLEND_OP   = 3'd5
  } cfg_reg_t;

  // Load enables of the four pipeline stages, first stage to last.
  typedef struct packed {
    logic sel;
    logic mul;
    logic div;
    logic comb;
  } stage_en_t;

  // Blend setting of one lane.
  typedef struct packed {
    logic [FACTOR_W-1:0] src_factor;
    logic [FACTOR_W-1:0] dst_factor;
    logic [OP_W-1:0]     op;
  } lane_cfg_t;

endpackage

/* sv/rcb_cfg_regs.sv */
// Configuration register file of the RGBA color blend unit.
module rcb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rcb_pkg::lane_cfg_t              rgb_cfg,
  output rcb_pkg::lane_cfg_t              alpha_cfg
);

  rcb_pkg::lane_cfg_t rgb_cfg_r;
  rcb_pkg::lane_cfg_t alpha_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_cfg_r.src_factor   <= rcb_pkg::FACT_ONE;
      rgb_cfg_r.dst_factor   <= rcb_pkg::FACT_ZERO;
      rgb_cfg_r.op           <= rcb_pkg::OP_ADD;
      alpha_cfg_r.src_factor <= rcb_pkg::FACT_ONE;
      alpha_cfg_r.dst_factor <= rcb_pkg::FACT_ZERO;
      alpha_cfg_r.op         <= rcb_pkg::OP_ADD;
    end else if (cfg_valid) begin
      case (cfg_index)
        rcb_pkg::REG_RGB_SRC_FACTOR:   rgb_cfg_r.src_factor   <= cfg_data;
        rcb_pkg::REG_RGB_DST_FACTOR:   rgb_cfg_r.dst_factor   <= cfg_data;
        rcb_pkg::REG_ALPHA_SRC_FACTOR: alpha_cfg_r.src_factor <= cfg_data;
        rcb_pkg::REG_ALPHA_DST_FACTOR: alpha_cfg_r.dst_factor <= cfg_data;
        rcb_pkg::REG_RGB_BLEND_OP:     rgb_cfg_r.op   <= cfg_data[rcb_pkg::OP_W-1:0];
        rcb_pkg::REG_ALPHA_BLEND_OP:   alpha_cfg_r.op <= cfg_data[rcb_pkg::OP_W-1:0];
        default: ;
      endcase
    end
  end

  assign rgb_cfg   = rgb_cfg_r;
  assign alpha_cfg = alpha_cfg_r;

endmodule

/* sv/rcb_lane.sv */
// Four-stage datapath of one color channel: factor select, multiply, divide, combine.
module rcb_lane #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  rcb_pkg::stage_en_t      en,
  input  rcb_pkg::lane_cfg_t      cfg,
  input  logic [CHANNEL_BITS-1:0] src_col,
  input  logic [CHANNEL_BITS-1:0] src_alpha,
  input  logic [CHANNEL_BITS-1:0] dst_col,
  input  logic [CHANNEL_BITS-1:0] dst_alpha,
  output logic [CHANNEL_BITS-1:0] blended
);

  localparam int unsigned N = CHANNEL_BITS;
  localparam logic [N-1:0] CH_MAX  = {N{1'b1}};
  localparam logic [2*N:0] HALF    = (2*N+1)'(CH_MAX >> 1);
  localparam logic [2*N:0] ONE_EXT = (2*N+1)'(1);

  function automatic logic [N-1:0] pick(input logic [rcb_pkg::FACTOR_W-1:0] code,
                                        input logic [N-1:0] s, input logic [N-1:0] sa,
                                        input logic [N-1:0] d, input logic [N-1:0] da);
    logic [N-1:0] f;
    case (code)
      rcb_pkg::FACT_ZERO:          f = '0;
      rcb_pkg::FACT_ONE:           f = CH_MAX;
      rcb_pkg::FACT_SRC_COL:       f = s;
      rcb_pkg::FACT_SRC_ALPHA:     f = sa;
      rcb_pkg::FACT_DST_COL:       f = d;
      rcb_pkg::FACT_DST_ALPHA:     f = da;
      rcb_pkg::FACT_INV_SRC_COL:   f = CH_MAX - s;
      rcb_pkg::FACT_INV_SRC_ALPHA: f = CH_MAX - sa;
      rcb_pkg::FACT_INV_DST_COL:   f = CH_MAX - d;
      rcb_pkg::FACT_INV_DST_ALPHA: f = CH_MAX - da;
      default:                     f = '0;
    endcase
    return f;
  endfunction

  // Rounded division by 2^N-1: y = p + M/2, then q = (y + (y >> N) + 1) >> N,
  // exact for every quotient up to M.
  function automatic logic [N-1:0] div_round(input logic [2*N-1:0] p);
    logic [2*N:0] y;
    logic [2*N:0] t;
    y = {1'b0, p} + HALF;
    t = y + (y >> N) + ONE_EXT;
    return t[2*N-1:N];
  endfunction

  // Stage 1: channel values and selected factors.
  logic [N-1:0] s_col_r, s_fac_r, d_col_r, d_fac_r;
  // Stage 2: products.
  logic [2*N-1:0] s_prod_r, d_prod_r;
  // Stage 3: weighted terms.
  logic [N-1:0] s_term_r, d_term_r;
  // Stage 4: blended channel.
  logic [N-1:0] blend_r, blend_nxt;
  logic [N:0]   sum;

  always_ff @(posedge clk) begin
    if (en.sel) begin
      s_col_r <= src_col;
      d_col_r <= dst_col;
      s_fac_r <= pick(cfg.src_factor, src_col, src_alpha, dst_col, dst_alpha);
      d_fac_r <= pick(cfg.dst_factor, src_col, src_alpha, dst_col, dst_alpha);
    end
    if (en.mul) begin
      s_prod_r <= s_col_r * s_fac_r;
      d_prod_r <= d_col_r * d_fac_r;
    end
    if (en.div) begin
      s_term_r <= div_round(s_prod_r);
      d_term_r <= div_round(d_prod_r);
    end
    if (en.comb) begin
      blend_r <= blend_nxt;
    end
  end

  assign sum = {1'b0, s_term_r} + {1'b0, d_term_r};

  always_comb begin
    case (cfg.op)
      rcb_pkg::OP_SUB:     blend_nxt = (s_term_r > d_term_r) ? s_term_r - d_term_r : '0;
      rcb_pkg::OP_REV_SUB: blend_nxt = (d_term_r > s_term_r) ? d_term_r - s_term_r : '0;
      rcb_pkg::OP_MIN:     blend_nxt = (s_term_r < d_term_r) ? s_term_r : d_term_r;
      rcb_pkg::OP_MAX:     blend_nxt = (s_term_r > d_term_r) ? s_term_r : d_term_r;
      default:             blend_nxt = sum[N] ? CH_MAX : sum[N-1:0];
    endcase
  end

  assign blended = blend_r;

endmodule

/* sv/rgba_color_blend_unit.sv */
// Top level of the RGBA color blend unit: stream ports, stage control, lanes.
//
// Usage: a source and a destination pixel enter as one transfer on the in_
// stream; the blended pixel leaves as one transfer on the out_ stream, in the
// same order. Blend factors and operations are set through the cfg_ write
// channel (index 0..5, other indexes ignored), which is always ready; write it
// only while no pixel is in flight.
// An input transfer passes four register stages on its way to the output:
// factor select, multiply, rounded division by the channel maximum, and
// combine. Throughput is one pixel per cycle while out_tready stays high, set
// by the four per-channel multiplier pairs working in parallel.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up while the receiver stalls and in_tready
// only drops once all four stages hold a pixel and out_tready is low.
// Reset empties the pipeline and sets the registers to source factor one,
// destination factor zero and add, which passes the source pixel through.
module rgba_color_blend_unit #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [8*CHANNEL_BITS-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_red, out_green, out_blue, out_alpha, zero padding to whole bytes
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned N     = CHANNEL_BITS;
  localparam int unsigned OUT_W = ((4*CHANNEL_BITS+7)/8)*8;

  rcb_pkg::lane_cfg_t rgb_cfg;
  rcb_pkg::lane_cfg_t alpha_cfg;
  rcb_pkg::stage_en_t en;

  logic [rcb_pkg::STAGES-1:0] vld_r;
  logic [N-1:0] src_ch [4];
  logic [N-1:0] dst_ch [4];
  logic [N-1:0] res_ch [4];

  rcb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rgb_cfg   (rgb_cfg),
    .alpha_cfg (alpha_cfg)
  );

  // A stage moves when it is empty or its successor moves.
  assign en.comb = !vld_r[3] || out_tready;
  assign en.div  = !vld_r[2] || en.comb;
  assign en.mul  = !vld_r[1] || en.div;
  assign en.sel  = !vld_r[0] || en.mul;

  assign in_tready  = en.sel;
  assign out_tvalid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en.sel)  vld_r[0] <= in_tvalid;
      if (en.mul)  vld_r[1] <= vld_r[0];
      if (en.div)  vld_r[2] <= vld_r[1];
      if (en.comb) vld_r[3] <= vld_r[2];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign src_ch[i] = in_tdata[i*N +: N];
    assign dst_ch[i] = in_tdata[(i+4)*N +: N];

    rcb_lane #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane (
      .clk       (clk),
      .en        (en),
      .cfg       ((i == 3) ? alpha_cfg : rgb_cfg),
      .src_col   (src_ch[i]),
      .src_alpha (src_ch[3]),
      .dst_col   (dst_ch[i]),
      .dst_alpha (dst_ch[3]),
      .blended   (res_ch[i])
    );
  end

  assign out_tdata = OUT_W'({res_ch[3], res_ch[2], res_ch[1], res_ch[0]});

  // An empty output stage never holds back the input.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // The input only stalls when every stage is full and the receiver waits.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&vld_r) && !out_tready))
    else $error("input stalled while the pipeline had room");

  // The first cycle after reset shows the pass-through setting.
  a_reset_setting: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (rgb_cfg.src_factor == rcb_pkg::FACT_ONE &&
                                  alpha_cfg.dst_factor == rcb_pkg::FACT_ZERO &&
                                  rgb_cfg.op == rcb_pkg::OP_ADD))
    else $error("configuration not at its reset setting after reset");

endmodule

/* verif/pixel_blend_checker.sv */
// Checker for the RGBA color blend unit: tracks the blend registers, predicts each pixel.
module pixel_blend_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          errors,
  output int          outstanding
);

  localparam logic [7:0] CH_MAX = 8'd255;

  // Lane 0 is red, lane 3 is alpha.
  typedef logic [3:0][7:0] rgba_t;

  rcb_pkg::lane_cfg_t rgb_set;
  rcb_pkg::lane_cfg_t alpha_set;
  rgba_t     expected_pixels[$];
  rgba_t     want;
  int        mismatch_count = 0;

  const string lane_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  function automatic logic [7:0] pick_weight(logic [3:0] code, logic [7:0] s, logic [7:0] sa,
                                             logic [7:0] d, logic [7:0] da);
    case (code)
      rcb_pkg::FACT_ZERO:          return 8'd0;
      rcb_pkg::FACT_ONE:           return CH_MAX;
      rcb_pkg::FACT_SRC_COL:       return s;
      rcb_pkg::FACT_SRC_ALPHA:     return sa;
      rcb_pkg::FACT_DST_COL:       return d;
      rcb_pkg::FACT_DST_ALPHA:     return da;
      rcb_pkg::FACT_INV_SRC_COL:   return CH_MAX - s;
      rcb_pkg::FACT_INV_SRC_ALPHA: return CH_MAX - sa;
      rcb_pkg::FACT_INV_DST_COL:   return CH_MAX - d;
      rcb_pkg::FACT_INV_DST_ALPHA: return CH_MAX - da;
      default:                     return 8'd0;
    endcase
  endfunction

  // Rounded c*f/255; 255 is odd, so there are no ties.
  function automatic logic [7:0] weigh_term(logic [7:0] c, logic [7:0] f);
    logic [16:0] prod;
    prod = c * f + 17'd127;
    return 8'(prod / 17'd255);
  endfunction

  function automatic logic [7:0] merge_terms(logic [7:0] a, logic [7:0] b, logic [2:0] op);
    logic [8:0] r;
    case (op)
      rcb_pkg::OP_SUB:     r = (a > b) ? 9'(a - b) : 9'd0;
      rcb_pkg::OP_REV_SUB: r = (b > a) ? 9'(b - a) : 9'd0;
      rcb_pkg::OP_MIN:     r = (a < b) ? 9'(a) : 9'(b);
      rcb_pkg::OP_MAX:     r = (a > b) ? 9'(a) : 9'(b);
      default:             r = 9'(a) + 9'(b);
    endcase
    return (r > 9'(CH_MAX)) ? CH_MAX : r[7:0];
  endfunction

  function automatic logic [7:0] blend_lane(logic [7:0] s, logic [7:0] sa, logic [7:0] d,
                                            logic [7:0] da, rcb_pkg::lane_cfg_t setting);
    logic [7:0] ts;
    logic [7:0] td;
    ts = weigh_term(s, pick_weight(setting.src_factor, s, sa, d, da));
    td = weigh_term(d, pick_weight(setting.dst_factor, s, sa, d, da));
    return merge_terms(ts, td, setting.op);
  endfunction

  function automatic rgba_t blend_pixel(logic [63:0] px);
    rgba_t res;
    for (int i = 0; i < 3; i++) begin
      res[i] = blend_lane(px[8*i +: 8], px[31:24], px[32+8*i +: 8], px[63:56], rgb_set);
    end
    res[3] = blend_lane(px[31:24], px[31:24], px[63:56], px[63:56], alpha_set);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rgb_set   = '{src_factor: rcb_pkg::FACT_ONE, dst_factor: rcb_pkg::FACT_ZERO,
                    op: rcb_pkg::OP_ADD};
      alpha_set = '{src_factor: rcb_pkg::FACT_ONE, dst_factor: rcb_pkg::FACT_ZERO,
                    op: rcb_pkg::OP_ADD};
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcb_pkg::REG_RGB_SRC_FACTOR:   rgb_set.src_factor   = cfg_data;
          rcb_pkg::REG_RGB_DST_FACTOR:   rgb_set.dst_factor   = cfg_data;
          rcb_pkg::REG_ALPHA_SRC_FACTOR: alpha_set.src_factor = cfg_data;
          rcb_pkg::REG_ALPHA_DST_FACTOR: alpha_set.dst_factor = cfg_data;
          rcb_pkg::REG_RGB_BLEND_OP:     rgb_set.op   = cfg_data[rcb_pkg::OP_W-1:0];
          rcb_pkg::REG_ALPHA_BLEND_OP:   alpha_set.op = cfg_data[rcb_pkg::OP_W-1:0];
          default: ;
        endcase
      end
      // Retire before queueing, so a pixel accepted in this cycle cannot cover a missing one.
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transfer: out_tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (out_tdata[8*i +: 8] !== want[i]) begin
              $error("%s mismatch: expected %0d, actual %0d", lane_name[i], want[i],
                     out_tdata[8*i +: 8]);
              mismatch_count++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(blend_pixel(in_tdata));
      end
    end
    outstanding <= expected_pixels.size();
    errors      <= mismatch_count;
  end

endmodule

/* verif/testbench.sv */
// Top of the testbench: clock, reset, pixel and register stimulus, verdict.
module testbench;

  localparam int unsigned RANDOM_PIXELS = 800;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned REG_COUNT     = 6;

  // Codes outside the defined ranges; the block treats them as zero factor or add.
  localparam logic [3:0] FACT_UNDEF_LO = 4'd10;
  localparam logic [3:0] FACT_UNDEF_HI = 4'd15;
  localparam logic [3:0] OP_UNDEF_LO   = 4'd5;
  localparam logic [3:0] OP_UNDEF_HI   = 4'd7;
  // Wider than an operation register: only the low three bits (max) survive.
  localparam logic [3:0] OP_OVERWIDE_MAX = 4'hC;
  // Same, with low bits that decode to an undefined operation.
  localparam logic [3:0] OP_OVERWIDE_ADD = 4'hF;

  typedef struct {
    logic [2:0] idx;
    logic [3:0] val;
  } reg_write_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [3:0]  cfg_data   = '0;

  int          errors;
  int          outstanding;
  int          quiet = 0;
  bit          tx_calm = 1'b0;
  bit          rx_on = 1'b0;
  int          rx_left = 0;
  int unsigned pixels_sent = 0;
  reg_write_t  reg_plan[$];

  always #1 clk = ~clk;

  rgba_color_blend_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pixel_blend_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int idle_run();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int ready_run();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
  endfunction

  // Channel values lean toward the ends of the range, where saturation and clamping happen.
  function automatic logic [7:0] rand_channel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'd0;
    if (r < 24) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_pixel();
    logic [63:0] px;
    for (int i = 0; i < 8; i++) px[8*i +: 8] = rand_channel();
    return px;
  endfunction

  // Register value: mostly a defined code, sometimes any 4-bit pattern.
  function automatic logic [3:0] rand_code(logic [3:0] top_code);
    return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, top_code));
  endfunction

  // The receiver alternates between ready runs and stalls of random length.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_on   = !rx_on;
      rx_left = rx_on ? ready_run() : idle_run();
    end
    rx_left--;
    out_tready <= rx_on;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_pixel(input logic [63:0] px);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_run();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every predicted pixel has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic plan_setting(input logic [3:0] rgb_src, input logic [3:0] rgb_dst,
                              input logic [3:0] a_src, input logic [3:0] a_dst,
                              input logic [3:0] rgb_op, input logic [3:0] a_op);
    reg_plan.push_back('{rcb_pkg::REG_RGB_SRC_FACTOR, rgb_src});
    reg_plan.push_back('{rcb_pkg::REG_RGB_DST_FACTOR, rgb_dst});
    reg_plan.push_back('{rcb_pkg::REG_ALPHA_SRC_FACTOR, a_src});
    reg_plan.push_back('{rcb_pkg::REG_ALPHA_DST_FACTOR, a_dst});
    reg_plan.push_back('{rcb_pkg::REG_RGB_BLEND_OP, rgb_op});
    reg_plan.push_back('{rcb_pkg::REG_ALPHA_BLEND_OP, a_op});
  endtask

  // Valid stays high across back-to-back register writes.
  task automatic program_regs();
    for (int i = 0; i < reg_plan.size(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_plan[i].idx;
      cfg_data  <= reg_plan[i].val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    reg_plan.delete();
  endtask

  task automatic run_setting(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
    drain();
    program_regs();
    push_pixel(a);
    push_pixel(b);
    push_pixel(c);
  endtask

  initial begin
    int unsigned burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting passes the source pixel through.
    push_pixel('0);
    push_pixel({64{1'b1}});
    push_pixel(64'h5555_5555_5555_5555);
    push_pixel(64'hAAAA_AAAA_AAAA_AAAA);
    push_pixel(64'h0000_0000_FFFF_FFFF);
    push_pixel(64'hFFFF_FFFF_0000_0000);

    // Classic alpha blending.
    plan_setting(rcb_pkg::FACT_SRC_ALPHA, rcb_pkg::FACT_INV_SRC_ALPHA, rcb_pkg::FACT_ONE,
                 rcb_pkg::FACT_INV_SRC_ALPHA, rcb_pkg::OP_ADD, rcb_pkg::OP_ADD);
    run_setting(64'h80FF_4000_C010_7FFF, {64{1'b1}}, rand_pixel());

    plan_setting(rcb_pkg::FACT_SRC_COL, rcb_pkg::FACT_DST_COL, rcb_pkg::FACT_DST_ALPHA,
                 rcb_pkg::FACT_SRC_ALPHA, rcb_pkg::OP_SUB, rcb_pkg::OP_REV_SUB);
    run_setting(64'h00FF_0080_FF00_80FF, 64'hFF00_FF00_00FF_00FF, rand_pixel());

    plan_setting(rcb_pkg::FACT_INV_SRC_COL, rcb_pkg::FACT_INV_DST_COL,
                 rcb_pkg::FACT_INV_DST_ALPHA, rcb_pkg::FACT_DST_ALPHA,
                 rcb_pkg::OP_MIN, rcb_pkg::OP_MAX);
    run_setting('0, 64'h1234_5678_9ABC_DEF0, rand_pixel());

    // Undefined factor and operation codes, plus writes to unused indexes.
    plan_setting(FACT_UNDEF_HI, FACT_UNDEF_LO, rcb_pkg::FACT_SRC_ALPHA, FACT_UNDEF_HI,
                 OP_UNDEF_LO, OP_UNDEF_HI);
    reg_plan.push_back('{3'(REG_COUNT), 4'(rcb_pkg::FACT_ONE)});
    reg_plan.push_back('{3'(REG_COUNT + 1), OP_OVERWIDE_MAX});
    run_setting({64{1'b1}}, 64'h7F80_017F_FE01_80C0, rand_pixel());

    // Operation values wider than the register.
    plan_setting(rcb_pkg::FACT_ONE, rcb_pkg::FACT_ONE, rcb_pkg::FACT_DST_COL,
                 rcb_pkg::FACT_INV_SRC_ALPHA, OP_OVERWIDE_MAX, OP_OVERWIDE_ADD);
    run_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'h0102_0304_FEFD_FCFB, rand_pixel());

    while (pixels_sent < RANDOM_PIXELS) begin
      drain();
      for (int unsigned r = 0; r < REG_COUNT; r++) begin
        if ($urandom_range(0, 4) != 0)
          reg_plan.push_back('{3'(r), rand_code((r < rcb_pkg::REG_ALPHA_DST_FACTOR + 1) ?
                                                4'(rcb_pkg::FACT_INV_DST_ALPHA) :
                                                4'(rcb_pkg::OP_MAX))});
      end
      if ($urandom_range(0, 5) == 0)
        reg_plan.push_back('{3'($urandom_range(REG_COUNT, 7)), 4'($urandom_range(0, 15))});
      program_regs();
      tx_calm = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(20, 100);
      for (int unsigned i = 0; i < burst; i++) push_pixel(rand_pixel());
      pixels_sent += burst;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
